/* sv/tsa_pkg.sv */
// Package for the table-based square root approximation.
// Holds the coarse and fine ROM tables and the bit-length helper.
// No dependencies.
`default_nettype none

package tsa_pkg;

    localparam int OPER_W  = 32;
    localparam int ROOT_W  = 16;
    localparam int KLEN_W  = 6;   // holds 0..32
    localparam int FRAC_W  = 5;
    localparam int COEF_W  = 16;
    localparam int PROD_W  = 2 * COEF_W;
    localparam int ROOT_LSB = 15; // floor(A*B*2/65536) == (A*B) >> 15

    typedef logic [OPER_W-1:0] t_operand;
    typedef logic [ROOT_W-1:0] t_root;
    typedef logic [KLEN_W-1:0] t_klen;
    typedef logic [FRAC_W-1:0] t_frac;
    typedef logic [COEF_W-1:0] t_coef;

    // floor(2^((k-1)/2)), zero for k == 0
    function automatic t_coef coarse_rom(input t_klen k);
        t_coef a;
        case (k)
            6'd0:    a = 16'd0;
            6'd1:    a = 16'd1;
            6'd2:    a = 16'd1;
            6'd3:    a = 16'd2;
            6'd4:    a = 16'd2;
            6'd5:    a = 16'd4;
            6'd6:    a = 16'd5;
            6'd7:    a = 16'd8;
            6'd8:    a = 16'd11;
            6'd9:    a = 16'd16;
            6'd10:   a = 16'd22;
            6'd11:   a = 16'd32;
            6'd12:   a = 16'd45;
            6'd13:   a = 16'd64;
            6'd14:   a = 16'd90;
            6'd15:   a = 16'd128;
            6'd16:   a = 16'd181;
            6'd17:   a = 16'd256;
            6'd18:   a = 16'd362;
            6'd19:   a = 16'd512;
            6'd20:   a = 16'd724;
            6'd21:   a = 16'd1024;
            6'd22:   a = 16'd1448;
            6'd23:   a = 16'd2048;
            6'd24:   a = 16'd2896;
            6'd25:   a = 16'd4096;
            6'd26:   a = 16'd5792;
            6'd27:   a = 16'd8192;
            6'd28:   a = 16'd11585;
            6'd29:   a = 16'd16384;
            6'd30:   a = 16'd23170;
            6'd31:   a = 16'd32768;
            6'd32:   a = 16'd46340;
            default: a = 16'd0;
        endcase
        return a;
    endfunction

    // floor(32768 * sqrt(1 + f/32))
    function automatic t_coef fine_rom(input t_frac f);
        t_coef b;
        case (f)
            5'd0:    b = 16'd32768;
            5'd1:    b = 16'd33276;
            5'd2:    b = 16'd33776;
            5'd3:    b = 16'd34269;
            5'd4:    b = 16'd34755;
            5'd5:    b = 16'd35235;
            5'd6:    b = 16'd35708;
            5'd7:    b = 16'd36174;
            5'd8:    b = 16'd36635;
            5'd9:    b = 16'd37090;
            5'd10:   b = 16'd37540;
            5'd11:   b = 16'd37984;
            5'd12:   b = 16'd38423;
            5'd13:   b = 16'd38858;
            5'd14:   b = 16'd39287;
            5'd15:   b = 16'd39712;
            5'd16:   b = 16'd40132;
            5'd17:   b = 16'd40548;
            5'd18:   b = 16'd40960;
            5'd19:   b = 16'd41367;
            5'd20:   b = 16'd41771;
            5'd21:   b = 16'd42170;
            5'd22:   b = 16'd42566;
            5'd23:   b = 16'd42959;
            5'd24:   b = 16'd43347;
            5'd25:   b = 16'd43733;
            5'd26:   b = 16'd44115;
            5'd27:   b = 16'd44493;
            5'd28:   b = 16'd44869;
            5'd29:   b = 16'd45241;
            5'd30:   b = 16'd45611;
            5'd31:   b = 16'd45977;
            default: b = 16'd32768;
        endcase
        return b;
    endfunction

    // position of the leading one plus one; zero for a zero value
    function automatic t_klen bit_length(input t_operand v);
        t_klen n;
        n = '0;
        for (int i = 0; i < OPER_W; i++) begin
            if (v[i]) begin
                n = KLEN_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* sv/tsa_datapath.sv */
// Combinational root datapath: bit length, normalize, table lookup, multiply.
// Depends on tsa_pkg.
`default_nettype none

module tsa_datapath
    import tsa_pkg::*;
(
    input  wire t_operand i_operand,
    output t_root         o_root
);

    t_klen                     klen;
    logic [OPER_W+KLEN_W-1:0]  norm_wide;
    t_frac                     frac;
    t_coef                     coef_a;
    t_coef                     coef_b;
    logic [PROD_W-1:0]         prod;

    always_comb begin
        klen      = bit_length(i_operand);
        // value * 64 >> k puts the leading one at bit 5 for any k
        norm_wide = {i_operand, {KLEN_W{1'b0}}} >> klen;
        frac      = norm_wide[FRAC_W-1:0];
        coef_a    = coarse_rom(klen);
        coef_b    = fine_rom(frac);
        prod      = PROD_W'(coef_a) * PROD_W'(coef_b);
        o_root    = prod[ROOT_LSB +: ROOT_W];
    end

endmodule

`default_nettype wire

/* sv/table_sqrt_approximation.sv */
// Table-based approximate integer square root, top level.
// Registered path: the input reg holds the accepted operand, the result reg holds the root.
// Throughput: one item per cycle while the output is not stalled; the single datapath pass sets the rate.
// Reset (synchronous, active low) empties both stages; no other state.
// Depends on tsa_pkg and tsa_datapath.
`default_nettype none

module table_sqrt_approximation
    import tsa_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_in_valid,
    output logic     o_in_ready,
    input  wire t_operand i_operand,
    output logic     o_out_valid,
    input  wire      i_out_ready,
    output t_root    o_root
);

    logic     r_in_vld;
    t_operand r_operand;
    logic     r_out_vld;
    t_root    r_root;
    t_root    root_calc;
    logic     out_en;

    // result stage can load when empty or being drained
    assign out_en     = !r_out_vld || i_out_ready;
    assign o_in_ready = !r_in_vld || out_en;

    tsa_datapath u_datapath (
        .i_operand (r_operand),
        .o_root    (root_calc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (out_en) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_operand <= i_operand;
        end
        if (out_en && r_in_vld) begin
            r_root <= root_calc;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_root      = r_root;

`ifndef SYNTH
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_in_vld)
        else $error("accepted item not held in input stage");

    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && out_en) |=> o_out_valid)
        else $error("input stage item lost on its way to result stage");

    a_zero_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && out_en && (r_operand == '0)) |=> (o_root == '0))
        else $error("zero operand gave nonzero root");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while both stages full and stalled");
`endif

endmodule

`default_nettype wire

/* tb/table_sqrt_approximation_tb.sv */
// Testbench for table_sqrt_approximation: drives operands over valid/ready
// and checks every root against an in-bench model of the table lookup.
// Depends on tsa_pkg and the table_sqrt_approximation RTL.
`timescale 1ns / 100ps

module table_sqrt_approximation_tb;
    import tsa_pkg::*;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_operand i_operand = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_root    o_root;

    // floor(2^((k-1)/2)) indexed by bit length, zero for an empty operand
    logic [15:0] coarse_factor [33] = '{
        16'd0, 16'd1, 16'd1, 16'd2, 16'd2, 16'd4, 16'd5, 16'd8, 16'd11, 16'd16,
        16'd22, 16'd32, 16'd45, 16'd64, 16'd90, 16'd128, 16'd181, 16'd256,
        16'd362, 16'd512, 16'd724, 16'd1024, 16'd1448, 16'd2048, 16'd2896,
        16'd4096, 16'd5792, 16'd8192, 16'd11585, 16'd16384, 16'd23170,
        16'd32768, 16'd46340
    };

    // floor(32768 * sqrt(1 + f/32)) indexed by the 5-bit mantissa fraction
    logic [15:0] fine_factor [32] = '{
        16'd32768, 16'd33276, 16'd33776, 16'd34269, 16'd34755, 16'd35235,
        16'd35708, 16'd36174, 16'd36635, 16'd37090, 16'd37540, 16'd37984,
        16'd38423, 16'd38858, 16'd39287, 16'd39712, 16'd40132, 16'd40548,
        16'd40960, 16'd41367, 16'd41771, 16'd42170, 16'd42566, 16'd42959,
        16'd43347, 16'd43733, 16'd44115, 16'd44493, 16'd44869, 16'd45241,
        16'd45611, 16'd45977
    };

    t_root expected_roots [$];
    int    mismatch_count = 0;
    int    sender_idle_pct = 0;
    int    receiver_stall_pct = 0;

    table_sqrt_approximation u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operand   (i_operand),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_root      (o_root)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_root approx_sqrt(input t_operand v);
        int unsigned msb_len;
        logic [31:0] mant;
        logic [31:0] prod;
        msb_len = 0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                msb_len = i + 1;
            end
        end
        // leading one goes to bit 5; short operands shift left
        if (msb_len <= 6) begin
            mant = v << (6 - msb_len);
        end else begin
            mant = v >> (msb_len - 6);
        end
        prod = (32'(coarse_factor[msb_len]) * 32'(fine_factor[mant[4:0]])) << 1;
        return prod[31:16];
    endfunction

    function automatic t_operand random_operand();
        int unsigned msb_len;
        t_operand v;
        case ($urandom_range(3))
            0: v = $urandom;
            1: begin
                // uniform over bit lengths, random bits below the leading one
                msb_len = $urandom_range(32);
                v = $urandom;
                if (msb_len < 32) begin
                    v = v & ((32'd1 << msb_len) - 32'd1);
                end
                if (msb_len > 0) begin
                    v[msb_len - 1] = 1'b1;
                end
            end
            2: v = $urandom_range(127);
            default: v = (32'd1 << $urandom_range(31)) + $urandom_range(3) - 32'd2;
        endcase
        return v;
    endfunction

    // valid is only lowered when a gap is actually taken
    task automatic send_operand(input t_operand v);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_operand  <= v;
        do @(posedge i_clk); while (!o_in_ready);
        expected_roots.push_back(approx_sqrt(v));
    endtask

    task automatic send_random_operands(input int count);
        for (int n = 0; n < count; n++) begin
            send_operand(random_operand());
        end
    endtask

    task automatic test_boundary_operands();
        t_operand corners [24] = '{
            32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
            32'h0000_0005, 32'h0000_0011, 32'h0000_001F, 32'h0000_0020,
            32'h0000_003F, 32'h0000_0040, 32'h0000_0041, 32'h0000_007F,
            32'h0000_FFFF, 32'h0001_0000, 32'h1234_5678, 32'h5555_5555,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hAAAA_AAAA,
            32'hC000_0000, 32'hF800_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
        };
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        foreach (corners[i]) begin
            send_operand(corners[i]);
        end
    endtask

    task automatic test_back_to_back();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_random_operands(385);
    endtask

    task automatic test_sender_gaps();
        sender_idle_pct    = 86;
        receiver_stall_pct = 0;
        send_random_operands(385);
    endtask

    task automatic test_receiver_stalls();
        sender_idle_pct    = 0;
        receiver_stall_pct = 86;
        send_random_operands(385);
    endtask

    task automatic test_mixed_idling();
        sender_idle_pct    = 31;
        receiver_stall_pct = 31;
        send_random_operands(385);
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_roots.size() == 0) begin
                $error("root: no item expected, actual %0d", o_root);
                mismatch_count++;
            end else begin
                if (o_root !== expected_roots[0]) begin
                    $error("root: expected %0d, actual %0d", expected_roots[0], o_root);
                    mismatch_count++;
                end
                void'(expected_roots.pop_front());
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_boundary_operands();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        i_in_valid <= 1'b0;
        while (expected_roots.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("table_sqrt_approximation: match");
        end else begin
            $display("table_sqrt_approximation: mismatch");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("table_sqrt_approximation: mismatch");
        $finish;
    end

endmodule
